>>> hdl/slt_pkg.sv
`default_nettype none

package slt_pkg;

  // Operation requested by an input transaction.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Status returned with every result transaction.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_t;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH   = 5;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;   // insert the key at its ordered place
    logic ers;   // remove the first entry that is not below the key
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/slt_cell.sv
`default_nettype none

module slt_cell
  import slt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire cell_ctl_t                     ctl,
  input  wire logic signed [VALUE_WIDTH-1:0] key,
  input  wire logic                          valid,
  input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
  input  wire logic                          left_le,
  input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
  output logic signed [VALUE_WIDTH-1:0]      entry,
  output logic                               le,
  output logic                               eq
);

  logic signed [VALUE_WIDTH-1:0] entry_r;
  logic signed [VALUE_WIDTH-1:0] entry_nxt;
  logic                          ge;

  assign entry = entry_r;
  assign le    = valid && (entry_r <= key);
  assign ge    = valid && (entry_r >= key);
  assign eq    = valid && (entry_r == key);

  // On insert the cell keeps its entry while it is not above the key; the first
  // cell past that point takes the key and the rest take their left neighbour.
  // On erase every cell from the first one not below the key takes its right
  // neighbour.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !le) begin
      entry_nxt = left_le ? key : left_entry;
    end else if (ctl.ers && ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/sorted_list_table.sv
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_func, in_operand_value
// out_     | output    | out_valid/out_stall| out_status, out_found, out_entry_count
//
// Each input transaction is finished at the edge that accepts it: the cell chain
// compares and shifts there, and the result is held in the output register.
// The output register is the only stage, so a new transaction is taken every
// cycle while results are drained; in_stall follows out_stall when a result waits.
// rst_n is synchronous and active low; it empties the table and the output register.
// Stored entries are not cleared: an entry is only ever read below the entry count.

`default_nettype none

module sorted_list_table
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_func,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_operand_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [COUNT_WIDTH-1:0]        out_entry_count
);

  localparam int unsigned OCC_WIDTH = $clog2(CAPACITY + 1);

  // Occupancy counter; cell i holds a valid entry when i is below it.
  logic [OCC_WIDTH-1:0] occ_r;
  logic [OCC_WIDTH-1:0] occ_nxt;

  // Output register.
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [1:0]             out_status_r;
  logic [1:0]             out_status_nxt;
  logic                   out_found_r;
  logic                   out_found_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic [COUNT_WIDTH-1:0] out_count_nxt;

  logic                          accept;
  func_t                         func;
  logic signed [VALUE_WIDTH-1:0] key;
  logic                          full;
  logic                          hit;
  cell_ctl_t                     ctl;
  logic [31:0]                   occ_wide;

  logic signed [VALUE_WIDTH-1:0] entry_v [CAPACITY];
  logic [CAPACITY-1:0]           valid_v;
  logic [CAPACITY-1:0]           le_v;
  logic [CAPACITY-1:0]           eq_v;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign func     = func_t'(in_func);
  // The size cast keeps the low bits, or sign-extends for a wider table.
  assign key      = VALUE_WIDTH'(in_operand_value);
  assign full     = (occ_r == OCC_WIDTH'(CAPACITY));
  // Only valid cells raise eq, so any match means the value is present.
  assign hit      = |eq_v;

  always_comb begin
    ctl.ins = accept && (func == FUNC_INSERT) && !full;
    ctl.ers = accept && (func == FUNC_ERASE) && hit;
  end

  // The chain of cells: each cell sees its neighbours' entries and the left
  // neighbour's ordering flag, and all of them update on the same edge.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_entry;
    logic                          left_le;
    logic signed [VALUE_WIDTH-1:0] right_entry;

    assign valid_v[i] = (occ_r > OCC_WIDTH'(i));

    if (i == 0) begin : g_first
      // The head of the chain behaves as if a smaller entry sat to its left.
      assign left_entry = key;
      assign left_le    = 1'b1;
    end else begin : g_inner
      assign left_entry = entry_v[i-1];
      assign left_le    = le_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // Nothing shifts in from beyond the tail; the count drops that entry.
      assign right_entry = entry_v[i];
    end else begin : g_body
      assign right_entry = entry_v[i+1];
    end

    slt_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .valid      (valid_v[i]),
      .left_entry (left_entry),
      .left_le    (left_le),
      .right_entry(right_entry),
      .entry      (entry_v[i]),
      .le         (le_v[i]),
      .eq         (eq_v[i])
    );
  end

  // Count and result for the transaction in hand.
  always_comb begin
    occ_nxt        = occ_r;
    out_status_nxt = STATUS_OK;
    out_found_nxt  = 1'b0;
    unique case (func)
      FUNC_INSERT: begin
        if (full) begin
          out_status_nxt = STATUS_FULL;
        end else begin
          occ_nxt = occ_r + OCC_WIDTH'(1);
        end
      end
      FUNC_ERASE: begin
        if (hit) begin
          occ_nxt       = occ_r - OCC_WIDTH'(1);
          out_found_nxt = 1'b1;
        end else begin
          out_status_nxt = STATUS_NOT_FOUND;
        end
      end
      FUNC_SEARCH: begin
        if (hit) begin
          out_found_nxt = 1'b1;
        end else begin
          out_status_nxt = STATUS_NOT_FOUND;
        end
      end
      FUNC_NOP: begin
        out_status_nxt = STATUS_OK;
      end
      default: begin
        out_status_nxt = STATUS_OK;
      end
    endcase
  end

  // The count field carries the occupancy modulo 32.
  assign occ_wide      = 32'(occ_nxt);
  assign out_count_nxt = occ_wide[COUNT_WIDTH-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_found_r  <= out_found_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

>>> hdl/slt_checker.sv
`default_nettype none

module slt_checker
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [1:0]             out_status,
  input wire logic                   out_found,
  input wire logic [COUNT_WIDTH-1:0] out_entry_count
);

  localparam logic [31:0] CAP_WORD = 32'(CAPACITY);

  // A result that is held back stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_found) && $stable(out_entry_count))
    else $error("stalled result transaction changed");

  // Every accepted transaction produces a result on the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction gave no result");

  // A found flag only comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == STATUS_OK)
    else $error("found flag with a failing status");

  // A dropped insert reports a full table: the count equals the capacity, modulo 32.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_entry_count == CAP_WORD[COUNT_WIDTH-1:0])
    else $error("full status with a count below capacity");

  // The reserved status code never appears.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != STATUS_RSVD)
    else $error("reserved status code on the result");

endmodule

bind sorted_list_table slt_checker #(
  .CAPACITY(CAPACITY)
) u_slt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_found      (out_found),
  .out_entry_count(out_entry_count)
);

`default_nettype wire
